[rtl/tceq_pkg.sv]
// ----------------------------------------------------------------------------
// tceq_pkg
// Shared field widths, operation codes and result codes of the timed
// coalescing event queue.
// ----------------------------------------------------------------------------
package tceq_pkg;

	localparam int OP_W    = 2;
	localparam int KIND_W  = 5;
	localparam int ARG_W   = 8;
	localparam int DELAY_W = 16;
	localparam int STAT_W  = 3;

	// kind + arg + typing flag + delay; the repeat count comes on top
	localparam int FIXED_W = KIND_W + ARG_W + 1 + DELAY_W;

	localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ENQ   = 2'd0,
		OP_TICK  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_NOTHING   = 3'd0,
		ST_APPENDED  = 3'd1,
		ST_COALESCED = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_DISPATCH  = 3'd4,
		ST_FLUSHED   = 3'd5
	} status_t;

endpackage

[rtl/timed_coalescing_event_queue.sv]
// ----------------------------------------------------------------------------
// timed_coalescing_event_queue
// FIFO of timed events with run-length coalescing of repeated enqueues.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation and the event fields with start high; the beat is taken
//   when start is high and busy is low. Operations: enqueue, one timer tick,
//   flush of all interactive entries.
//   Every accepted beat gives exactly one result: done is high for one cycle
//   with status, out_kind, out_arg, idle_pulse, entries_used and
//   removed_count. The receiver cannot stall; the result must be taken then.
//   Steps (all entries live in one RAM with one read port, registered read):
//     enqueue          read tail, then write back
//     tick             read head; when the head entry retires and another
//                      entry follows, an extra read of the new head delay
//     flush            walk of all entries, one entry read per cycle (kept
//                      entries written back compacted)
//     unknown op       answered directly from idle
//   The result is registered; a new beat can be accepted in the cycle the
//   previous result is shown, except after a tick with the extra read.
//   Reset empties the queue and disarms the timer; no RAM clearing pass is
//   needed, since the contents of unwritten entries are never used.
// ----------------------------------------------------------------------------
module timed_coalescing_event_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KIND_COUNT  = 24,
	parameter int REPEAT_BITS = 16,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tceq_pkg::OP_W-1:0]     operation,
	input  logic [tceq_pkg::KIND_W-1:0]   event_kind,
	input  logic [tceq_pkg::ARG_W-1:0]    event_arg,
	input  logic                          from_typing,
	input  logic [tceq_pkg::DELAY_W-1:0]  wait_ticks,
	output logic                          done,
	output logic [tceq_pkg::STAT_W-1:0]   status,
	output logic [tceq_pkg::KIND_W-1:0]   out_kind,
	output logic [tceq_pkg::ARG_W-1:0]    out_arg,
	output logic                          idle_pulse,
	output logic [CNT_W-1:0]              entries_used,
	output logic [CNT_W-1:0]              removed_count
);

	localparam int IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int ENTRY_W   = tceq_pkg::FIXED_W + REPEAT_BITS;
	localparam int DELAY_LSB = REPEAT_BITS;
	localparam int TYP_BIT   = DELAY_LSB + tceq_pkg::DELAY_W;
	localparam int ARG_LSB   = TYP_BIT + 1;
	localparam int KIND_LSB  = ARG_LSB + tceq_pkg::ARG_W;

	localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]       FULL_CNT  = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0]       ONE_CNT   = CNT_W'(1);
	localparam logic [REPEAT_BITS-1:0] REP_MAX   = {REPEAT_BITS{1'b1}};
	localparam logic [REPEAT_BITS-1:0] REP_ONE   = REPEAT_BITS'(1);
	localparam logic [REPEAT_BITS-1:0] REP_TWO   = REPEAT_BITS'(2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_TICK,
		S_ARM,
		S_FLUSH
	} state_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - IDX_W'(1);
	endfunction

	// queue control state
	state_t                          state_q;
	logic [IDX_W-1:0]                head_q, tail_q;
	logic [CNT_W-1:0]                total_q;
	logic [tceq_pkg::DELAY_W-1:0]    elapsed_q, armed_q;

	// latched input beat
	logic [tceq_pkg::KIND_W-1:0]     kind_q;
	logic [tceq_pkg::ARG_W-1:0]      arg_q;
	logic                            typing_q;
	logic [tceq_pkg::DELAY_W-1:0]    wait_q;

	// flush walk
	logic [IDX_W-1:0]                fl_rd_q, fl_wr_q;
	logic [CNT_W-1:0]                fl_cnt_q, fl_kept_q, fl_rem_q;
	logic                            fl_vld_s1, fl_first_q, fl_gone_q;
	logic [tceq_pkg::DELAY_W-1:0]    fl_delay_q;

	// result registers
	logic                            done_q, idle_q;
	tceq_pkg::status_t               status_q;
	logic [tceq_pkg::KIND_W-1:0]     okind_q;
	logic [tceq_pkg::ARG_W-1:0]      oarg_q;
	logic [CNT_W-1:0]                used_q, removed_q;

	// RAM ports
	logic                            ram_we;
	logic [IDX_W-1:0]                ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]              ram_wdata, ram_rdata;

	// read entry fields
	logic [tceq_pkg::KIND_W-1:0]     rd_kind;
	logic [tceq_pkg::ARG_W-1:0]      rd_arg;
	logic                            rd_typing;
	logic [tceq_pkg::DELAY_W-1:0]    rd_delay;
	logic [REPEAT_BITS-1:0]          rd_rep;

	logic [IDX_W-1:0]                tail_prev, head_nx;
	logic [tceq_pkg::DELAY_W-1:0]    tick_elapsed;
	logic                            tick_fire, kind_ok, tail_match;
	tceq_pkg::status_t               enq_status;

	assign busy = (state_q != S_IDLE);

	assign rd_kind   = ram_rdata[KIND_LSB +: tceq_pkg::KIND_W];
	assign rd_arg    = ram_rdata[ARG_LSB +: tceq_pkg::ARG_W];
	assign rd_typing = ram_rdata[TYP_BIT];
	assign rd_delay  = ram_rdata[DELAY_LSB +: tceq_pkg::DELAY_W];
	assign rd_rep    = ram_rdata[REPEAT_BITS-1:0];

	assign tail_prev    = idx_dec(tail_q);
	assign head_nx      = idx_inc(head_q);
	assign tick_elapsed = (elapsed_q == tceq_pkg::DELAY_MAX) ? elapsed_q
	                                                         : elapsed_q + 16'd1;
	assign tick_fire    = (tick_elapsed >= armed_q);
	assign kind_ok      = (int'(kind_q) < KIND_COUNT);
	assign tail_match   = (total_q != '0) && (rd_kind == kind_q) && (rd_arg == arg_q)
	                   && (rd_typing == typing_q) && (rd_delay == wait_q)
	                   && (rd_rep != REP_MAX);

	always_comb begin
		if (!kind_ok) begin
			enq_status = tceq_pkg::ST_NOTHING;
		end else if (tail_match) begin
			enq_status = tceq_pkg::ST_COALESCED;
		end else if (total_q == FULL_CNT) begin
			enq_status = tceq_pkg::ST_DROPPED;
		end else begin
			enq_status = tceq_pkg::ST_APPENDED;
		end
	end

	// RAM access per state
	always_comb begin
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {kind_q, arg_q, typing_q, wait_q, REP_ONE};
		case (state_q)
			S_IDLE: begin
				if (tceq_pkg::op_t'(operation) == tceq_pkg::OP_ENQ) begin
					ram_raddr = tail_prev;
				end
			end
			S_ENQ: begin
				if (enq_status == tceq_pkg::ST_COALESCED) begin
					ram_we    = 1'b1;
					ram_waddr = tail_prev;
					ram_wdata = {ram_rdata[ENTRY_W-1:REPEAT_BITS], rd_rep + REP_ONE};
				end else if (enq_status == tceq_pkg::ST_APPENDED) begin
					ram_we = 1'b1;
				end
			end
			S_TICK: begin
				// fetch the next head in case this one retires
				ram_raddr = head_nx;
				if (total_q != '0 && tick_fire && rd_rep >= REP_TWO) begin
					ram_we    = 1'b1;
					ram_waddr = head_q;
					ram_wdata = {ram_rdata[ENTRY_W-1:REPEAT_BITS], rd_rep - REP_ONE};
				end
			end
			S_FLUSH: begin
				ram_raddr = fl_rd_q;
				if (fl_vld_s1 && !rd_typing) begin
					ram_we    = 1'b1;
					ram_waddr = fl_wr_q;
					ram_wdata = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	tceq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q   <= event_kind;
			arg_q    <= event_arg;
			typing_q <= from_typing;
			wait_q   <= wait_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			total_q    <= '0;
			elapsed_q  <= '0;
			armed_q    <= '0;
			fl_rd_q    <= '0;
			fl_wr_q    <= '0;
			fl_cnt_q   <= '0;
			fl_kept_q  <= '0;
			fl_rem_q   <= '0;
			fl_vld_s1  <= 1'b0;
			fl_first_q <= 1'b0;
			fl_gone_q  <= 1'b0;
			fl_delay_q <= '0;
			done_q     <= 1'b0;
			status_q   <= tceq_pkg::ST_NOTHING;
			okind_q    <= '0;
			oarg_q     <= '0;
			idle_q     <= 1'b0;
			used_q     <= '0;
			removed_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (tceq_pkg::op_t'(operation))
							tceq_pkg::OP_ENQ:  state_q <= S_ENQ;
							tceq_pkg::OP_TICK: state_q <= S_TICK;
							tceq_pkg::OP_FLUSH: begin
								fl_rd_q    <= head_nx;
								fl_wr_q    <= head_q;
								fl_cnt_q   <= ONE_CNT;
								fl_vld_s1  <= (total_q != '0);
								fl_kept_q  <= '0;
								fl_rem_q   <= '0;
								fl_first_q <= 1'b1;
								fl_gone_q  <= 1'b0;
								state_q    <= S_FLUSH;
							end
							default: begin
								done_q    <= 1'b1;
								status_q  <= tceq_pkg::ST_NOTHING;
								okind_q   <= '0;
								oarg_q    <= '0;
								idle_q    <= 1'b0;
								used_q    <= total_q;
								removed_q <= '0;
							end
						endcase
					end
				end
				S_ENQ: begin
					done_q    <= 1'b1;
					status_q  <= enq_status;
					okind_q   <= '0;
					oarg_q    <= '0;
					idle_q    <= 1'b0;
					removed_q <= '0;
					used_q    <= total_q;
					if (enq_status == tceq_pkg::ST_APPENDED) begin
						tail_q  <= idx_inc(tail_q);
						total_q <= total_q + ONE_CNT;
						used_q  <= total_q + ONE_CNT;
						if (total_q == '0) begin
							armed_q   <= wait_q;
							elapsed_q <= '0;
						end
					end
					state_q <= S_IDLE;
				end
				S_TICK: begin
					done_q    <= 1'b1;
					status_q  <= tceq_pkg::ST_NOTHING;
					okind_q   <= '0;
					oarg_q    <= '0;
					idle_q    <= 1'b0;
					removed_q <= '0;
					used_q    <= total_q;
					state_q   <= S_IDLE;
					if (total_q != '0) begin
						elapsed_q <= tick_elapsed;
						if (tick_fire) begin
							status_q  <= tceq_pkg::ST_DISPATCH;
							okind_q   <= rd_kind;
							oarg_q    <= rd_arg;
							elapsed_q <= '0;
							if (rd_rep < REP_TWO) begin
								// retire the head, re-arm from the next one if any
								head_q  <= head_nx;
								total_q <= total_q - ONE_CNT;
								used_q  <= total_q - ONE_CNT;
								if (total_q == ONE_CNT) begin
									armed_q <= '0;
									idle_q  <= 1'b1;
								end else begin
									state_q <= S_ARM;
								end
							end
						end
					end
				end
				S_ARM: begin
					armed_q <= rd_delay;
					state_q <= S_IDLE;
				end
				S_FLUSH: begin
					if (fl_vld_s1) begin
						fl_first_q <= 1'b0;
						if (rd_typing) begin
							fl_rem_q <= fl_rem_q + ONE_CNT;
							if (fl_first_q) begin
								fl_gone_q <= 1'b1;
							end
						end else begin
							fl_wr_q   <= idx_inc(fl_wr_q);
							fl_kept_q <= fl_kept_q + ONE_CNT;
							if (fl_kept_q == '0) begin
								fl_delay_q <= rd_delay;
							end
						end
						// issue the next read while entries remain
						if (fl_cnt_q < total_q) begin
							fl_rd_q   <= idx_inc(fl_rd_q);
							fl_cnt_q  <= fl_cnt_q + ONE_CNT;
							fl_vld_s1 <= 1'b1;
						end else begin
							fl_vld_s1 <= 1'b0;
						end
					end else begin
						total_q <= fl_kept_q;
						tail_q  <= fl_wr_q;
						if (fl_kept_q == '0 || fl_gone_q) begin
							elapsed_q <= '0;
							armed_q   <= (fl_kept_q == '0) ? '0 : fl_delay_q;
						end
						done_q    <= 1'b1;
						status_q  <= tceq_pkg::ST_FLUSHED;
						okind_q   <= '0;
						oarg_q    <= '0;
						idle_q    <= 1'b0;
						used_q    <= fl_kept_q;
						removed_q <= fl_rem_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign out_kind      = okind_q;
	assign out_arg       = oarg_q;
	assign idle_pulse    = idle_q;
	assign entries_used  = used_q;
	assign removed_count = removed_q;

	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted beat neither in progress nor answered");

	a_idle_means_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle_pulse) |->
			(status == tceq_pkg::ST_DISPATCH && entries_used == '0 && total_q == '0))
		else $error("idle pulse without an emptying dispatch");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= FULL_CNT)
		else $error("entry count above queue depth");

	a_removed_only_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != tceq_pkg::ST_FLUSHED) |-> (removed_count == '0))
		else $error("removed count outside a flush result");

	a_flush_conserves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && !fl_vld_s1) |-> (fl_kept_q + fl_rem_q == total_q))
		else $error("flush walk lost or duplicated entries");

endmodule

[rtl/tceq_ram.sv]
// ----------------------------------------------------------------------------
// tceq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module tceq_ram #(
	parameter int WIDTH  = 46,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
